>>> src/tli_pkg.sv
`default_nettype none
package tli_pkg;

  localparam int BP_W  = 16;
  localparam int VAL_W = 32;
  localparam int WT_W  = 17;
  localparam int CNT_W = 9;

  localparam logic [WT_W-1:0] HALF_WEIGHT = 17'd32768;
  localparam logic [WT_W-1:0] ONE_WEIGHT  = 17'd65536;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [BP_W-1:0]  bp;
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_DIV,
    S_BLEND,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

>>> src/tli_table.sv
`default_nettype none
module tli_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  tli_pkg::entry_t   wdata,
  input  logic [AW-1:0]     raddr,
  output tli_pkg::entry_t   rdata
);
  import tli_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/tli_div.sv
`default_nettype none
module tli_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [tli_pkg::BP_W-1:0] num,
  input  logic [tli_pkg::BP_W-1:0] den,
  output logic                    done,
  output logic [tli_pkg::BP_W-1:0] quot
);
  import tli_pkg::*;

  localparam int STEP_W = $clog2(BP_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [BP_W-1:0]   rem;
  logic [BP_W-1:0]   den_q;
  logic [BP_W:0]     trial;
  logic [BP_W:0]     diff;
  logic              geq;

  // restoring division of (num << 16) by den, one quotient bit per cycle
  always_comb begin
    trial = {rem, 1'b0};
    diff  = trial - {1'b0, den_q};
    geq   = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy  <= 1'b1;
        steps <= STEP_W'(BP_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem   <= num;
      den_q <= den;
      quot  <= '0;
    end else if (busy) begin
      rem  <= geq ? diff[BP_W-1:0] : trial[BP_W-1:0];
      quot <= {quot[BP_W-2:0], geq};
    end
  end

endmodule
`default_nettype wire

>>> src/tli_blend.sv
`default_nettype none
module tli_blend (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic signed [tli_pkg::VAL_W-1:0] v_lo,
  input  logic signed [tli_pkg::VAL_W-1:0] v_hi,
  input  logic [tli_pkg::WT_W-1:0]         weight,
  output logic                            done,
  output logic signed [tli_pkg::VAL_W-1:0] result
);
  import tli_pkg::*;

  localparam int DIFF_W = VAL_W + 1;
  localparam int PROD_W = DIFF_W + WT_W + 1;

  logic signed [DIFF_W-1:0] diff;
  logic signed [WT_W:0]     w_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  v_lo_q;
  logic                     stage1;

  // vl*(1-w) + vh*w == vl + (vh - vl)*w, floor taken by the arithmetic shift
  always_comb begin
    diff = {v_hi[VAL_W-1], v_hi} - {v_lo[VAL_W-1], v_lo};
    w_s  = signed'({1'b0, weight});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= go;
      done   <= stage1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod   <= diff * w_s;
      v_lo_q <= v_lo;
    end
    if (stage1) begin
      result <= v_lo_q + signed'(prod[VAL_W+15:16]);
    end
  end

endmodule
`default_nettype wire

>>> src/table_linear_interpolation.sv
`default_nettype none
// a write beat leaves the FSM in S_IDLE, so the next beat is taken in the following cycle
// a query clamped to an end entry passes S_FIRST, S_LAST, S_BLEND and S_OUT; otherwise
// the linear search in S_SCAN reads k entries (one table read per cycle, k equals
// upper_slot) and the bit-serial weight division runs in S_DIV before S_BLEND and S_OUT
// a query holds off the input (s_tready low) until S_IDLE; an unaccepted result beat stalls S_OUT
// reset clears control and sets entries_in_use to 2; table contents stay undefined
module table_linear_interpolation #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // entry_index, z_value, entry_value
  input  logic [0:0]   s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // interpolated_value, clamped_z, lower_slot,
                                  // upper_slot, upper_weight, lower_weight, pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data
);
  import tli_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (CW > CNT_W) ? CW : CNT_W;

  state_t state, state_next;

  logic [CNT_W-1:0] entries_in_use;
  logic [NW-1:0]    n_ext;
  logic [NW-1:0]    n_lim;
  logic [AW-1:0]    last_idx;

  logic             in_cmd;
  logic [7:0]       in_index;
  logic [BP_W-1:0]  in_z;
  logic [VAL_W-1:0] in_val;
  logic             in_beat;

  logic             tbl_we;
  entry_t           tbl_wdata;
  logic [AW-1:0]    tbl_raddr;
  entry_t           rdata;

  logic [BP_W-1:0]         z_q;
  logic [BP_W-1:0]         zc;
  logic [BP_W-1:0]         bl;
  logic signed [VAL_W-1:0] vl;
  logic signed [VAL_W-1:0] vh;
  logic [AW-1:0]           lo;
  logic [AW-1:0]           hi;
  logic [AW-1:0]           cnt;
  logic [WT_W-1:0]         wu;
  logic [BP_W-1:0]         num;
  logic [BP_W-1:0]         den;

  logic                    clamp_lo;
  logic                    clamp_hi;
  logic                    found;
  logic                    out_free;

  logic                    div_go;
  logic                    div_done;
  logic [BP_W-1:0]         quot;
  logic                    blend_go;
  logic                    blend_done;
  logic signed [VAL_W-1:0] blend_result;

  assign in_cmd   = s_tuser[0];
  assign in_index = s_tdata[7:0];
  assign in_z     = s_tdata[23:8];
  assign in_val   = s_tdata[55:24];

  assign s_tready  = (state == S_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CNT_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  // active count limited to [2, TABLE_DEPTH]
  always_comb begin
    n_ext = NW'(entries_in_use);
    if (n_ext < NW'(2)) begin
      n_lim = NW'(1);
    end else if (n_ext > NW'(TABLE_DEPTH)) begin
      n_lim = NW'(TABLE_DEPTH - 1);
    end else begin
      n_lim = n_ext - NW'(1);
    end
    last_idx = n_lim[AW-1:0];
  end

  assign tbl_we = in_beat && (in_cmd == CMD_WRITE) &&
                  (NW'(in_index) < NW'(TABLE_DEPTH));
  assign tbl_wdata = '{bp: in_z, val: in_val};

  always_comb begin
    unique case (state)
      S_IDLE:  tbl_raddr = '0;
      S_FIRST: tbl_raddr = last_idx;
      S_LAST:  tbl_raddr = AW'(1);
      S_SCAN:  tbl_raddr = cnt + AW'(1);
      default: tbl_raddr = '0;
    endcase
  end

  tli_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_index)),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (rdata)
  );

  // in S_LAST, bl holds the first breakpoint and rdata the last entry
  assign clamp_lo = (z_q <= bl);
  assign clamp_hi = (z_q >= rdata.bp);
  assign found    = (rdata.bp > z_q);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_beat && (in_cmd == CMD_QUERY)) state_next = S_FIRST;
      end
      S_FIRST: state_next = S_LAST;
      S_LAST: begin
        state_next = (clamp_lo || clamp_hi) ? S_BLEND : S_SCAN;
      end
      S_SCAN: begin
        if (found) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_BLEND;
      end
      S_BLEND: begin
        if (blend_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_go   <= 1'b0;
      blend_go <= 1'b0;
    end else begin
      div_go   <= (state == S_SCAN) && found;
      blend_go <= ((state == S_LAST) && (clamp_lo || clamp_hi)) ||
                  ((state == S_DIV) && div_done);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        z_q <= in_z;
      end
      S_FIRST: begin
        bl <= rdata.bp;
        vl <= signed'(rdata.val);
      end
      S_LAST: begin
        wu <= HALF_WEIGHT;
        if (clamp_lo) begin
          zc <= bl;
          vh <= vl;
          lo <= '0;
          hi <= '0;
        end else if (clamp_hi) begin
          zc <= rdata.bp;
          vl <= signed'(rdata.val);
          vh <= signed'(rdata.val);
          lo <= last_idx;
          hi <= last_idx;
        end else begin
          zc  <= z_q;
          cnt <= AW'(1);
        end
      end
      S_SCAN: begin
        if (found) begin
          hi  <= cnt;
          lo  <= cnt - AW'(1);
          vh  <= signed'(rdata.val);
          num <= z_q - bl;
          den <= rdata.bp - bl;
        end else begin
          bl  <= rdata.bp;
          vl  <= signed'(rdata.val);
          cnt <= cnt + AW'(1);
        end
      end
      S_DIV: begin
        if (div_done) wu <= {1'b0, quot};
      end
      default: begin
      end
    endcase
  end

  tli_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quot (quot)
  );

  tli_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .go     (blend_go),
    .v_lo   (vl),
    .v_hi   (vh),
    .weight (wu),
    .done   (blend_done),
    .result (blend_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_tdata <= {6'b0, ONE_WEIGHT - wu, wu, 8'(hi), 8'(lo), zc, blend_result};
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tli_pkg::*;

  localparam int ITEM_TARGET = 1900;
  localparam int QUIET_LIMIT = 4000;
  localparam int DEPTH       = 256;

  typedef struct {
    logic [31:0] value;
    logic [15:0] z;
    logic [7:0]  lower;
    logic [7:0]  upper;
    logic [16:0] w_up;
    logic [16:0] w_low;
  } interp_result_t;

  class interp_scoreboard;
    logic [15:0]    bp_tab [DEPTH];
    logic [31:0]    val_tab [DEPTH];
    int unsigned    entry_count;
    interp_result_t pending_q [$];
    int             errors;

    function new();
      entry_count = 2;
      errors = 0;
    endfunction

    function void set_count(logic [8:0] cnt);
      entry_count = {23'b0, cnt};
    endfunction

    function int unsigned active_entries();
      if (entry_count < 2) return 2;
      if (entry_count > DEPTH) return DEPTH;
      return entry_count;
    endfunction

    // stores a table entry, or works out the interpolation a query gives
    function void note_input(logic cmd, logic [7:0] idx, logic [15:0] z, logic [31:0] v);
      int unsigned       n, i, lo_i, hi_i, zi, zc, wu, wl, first, last, bl, bh, num;
      longint unsigned   scaled;
      longint            vh, vl, acc;
      bit                found;
      interp_result_t    r;
      if (cmd == CMD_WRITE) begin
        bp_tab[idx] = z;
        val_tab[idx] = v;
        return;
      end
      zi = z;
      n = active_entries();
      first = bp_tab[0];
      last = bp_tab[n-1];
      if (zi > first && zi < last) begin
        hi_i = n - 1;
        found = 1'b0;
        for (i = 0; i < n; i++) begin
          if (!found && bp_tab[i] > zi) begin
            hi_i = i;
            found = 1'b1;
          end
        end
        if (hi_i == 0) hi_i = 1;
        lo_i = hi_i - 1;
        zc = zi;
        bl = bp_tab[lo_i];
        bh = bp_tab[hi_i];
        if (bh > bl && zi >= bl) begin
          num = zi - bl;
          if (num > bh - bl) num = bh - bl;
          scaled = num;
          scaled = (scaled << 16) / (bh - bl);
          wu = scaled[31:0];
        end else begin
          wu = 0;
        end
      end else if (zi <= first) begin
        zc = first;
        lo_i = 0;
        hi_i = 0;
        wu = HALF_WEIGHT;
      end else begin
        zc = last;
        lo_i = n - 1;
        hi_i = n - 1;
        wu = HALF_WEIGHT;
      end
      if (wu > ONE_WEIGHT) wu = ONE_WEIGHT;
      wl = ONE_WEIGHT - wu;
      vh = $signed(val_tab[hi_i]);
      vl = $signed(val_tab[lo_i]);
      acc = vh * longint'(wu) + vl * longint'(wl);
      // arithmetic shift gives floor rounding
      acc = acc >>> 16;
      r.value = acc[31:0];
      r.z = zc[15:0];
      r.lower = lo_i[7:0];
      r.upper = hi_i[7:0];
      r.w_up = wu[16:0];
      r.w_low = wl[16:0];
      pending_q.insert(pending_q.size(), r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [103:0] d);
      interp_result_t want, got;
      got.value = d[31:0];
      got.z     = d[47:32];
      got.lower = d[55:48];
      got.upper = d[63:56];
      got.w_up  = d[80:64];
      got.w_low = d[97:81];
      if (pending_q.size() == 0) begin
        report($sformatf("result beat with nothing outstanding, data %h", d));
        return;
      end
      want = pending_q.pop_front();
      if (got.value !== want.value)
        report($sformatf("interpolated_value %h, want %h", got.value, want.value));
      if (got.z !== want.z)
        report($sformatf("clamped_z %h, want %h", got.z, want.z));
      if (got.lower !== want.lower)
        report($sformatf("lower_slot %0d, want %0d", got.lower, want.lower));
      if (got.upper !== want.upper)
        report($sformatf("upper_slot %0d, want %0d", got.upper, want.upper));
      if (got.w_up !== want.w_up)
        report($sformatf("upper_weight %0d, want %0d", got.w_up, want.w_up));
      if (got.w_low !== want.w_low)
        report($sformatf("lower_weight %0d, want %0d", got.w_low, want.w_low));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;    // entry_index, z_value, entry_value
  logic [0:0]   s_tuser = '0;    // cmd
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;         // interpolated_value, clamped_z, lower_slot,
                                 // upper_slot, upper_weight, lower_weight, pad
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [8:0]   cfg_data = '0;

  interp_scoreboard sb = new();
  int unsigned      items_sent = 0;
  int unsigned      quiet_cycles = 0;
  bit               no_idle = 1'b0;

  always #4 clk = ~clk;

  table_linear_interpolation #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // result side: random backpressure (none while no_idle), beats checked from values stable at negedge
  always @(posedge clk) begin
    m_tready <= !rst && (no_idle || $urandom_range(0, 99) >= 13);
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // query coordinates cluster at the table ends and around the breakpoints
  function automatic logic [15:0] pick_query_z();
    int unsigned n, k, first, last, r;
    int          near;
    n = sb.active_entries();
    first = sb.bp_tab[0];
    last = sb.bp_tab[n-1];
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if (r < 45) begin
      k = $urandom_range(0, n - 1);
      near = int'(sb.bp_tab[k]) + int'($urandom_range(0, 2)) - 1;
      return near[15:0];
    end
    if (r < 60) begin
      return $urandom_range(0, 1) ? 16'($urandom_range(0, first))
                                  : 16'($urandom_range(last, 65535));
    end
    if (first < last) return 16'($urandom_range(first, last));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_item(logic cmd, logic [7:0] idx, logic [15:0] z, logic [31:0] v);
    while (!no_idle && $urandom_range(0, 99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {v, z, idx};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    sb.note_input(cmd, idx, z, v);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  task automatic write_count(logic [8:0] cnt);
    drain();
    // quiet gap before the count changes
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cnt;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    sb.set_count(cnt);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly strictly increasing tables; some with repeats, some unsorted
  task automatic load_table(int unsigned n);
    int unsigned bp [DEPTH];
    int unsigned lo, top, stride, shape, i;
    shape = $urandom_range(0, 9);
    lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30000);
    if ($urandom_range(0, 7) == 0) top = lo + n - 1;
    else if ($urandom_range(0, 2) == 0) top = 65535;
    else top = $urandom_range(lo + n - 1, 65535);
    stride = (top - lo) / (n - 1);
    for (i = 0; i < n; i++) begin
      bp[i] = lo + i * stride;
      if (i > 0 && i < n - 1 && stride > 1) bp[i] += $urandom_range(0, stride - 1);
    end
    bp[n-1] = top;
    if (shape == 8) begin
      for (i = 1; i < n; i++) if ($urandom_range(0, 2) == 0) bp[i] = bp[i-1];
    end else if (shape == 9) begin
      for (i = 0; i < n; i++) bp[i] = $urandom_range(0, 65535);
    end
    for (i = 0; i < n; i++) send_item(CMD_WRITE, i[7:0], bp[i][15:0], random_value());
  endtask

  task automatic run_phase(logic [8:0] cnt);
    int unsigned n, j, r, k, body_len;
    write_count(cnt);
    n = sb.active_entries();
    load_table(n);
    // long searches are slow, so big tables get short bodies
    body_len = (n > 64) ? 25 : $urandom_range(60, 160);
    for (j = 0; j < body_len && items_sent < ITEM_TARGET; j++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        drain();
      end else if (r < 15) begin
        k = $urandom_range(0, n - 1);
        send_item(CMD_WRITE, k[7:0], sb.bp_tab[k], random_value());
      end else if (r < 22) begin
        send_item(CMD_WRITE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  random_value());
      end else begin
        send_item(CMD_QUERY, 8'($urandom_range(0, 255)), pick_query_z(), $urandom);
      end
    end
  endtask

  initial begin
    logic [8:0] cnt;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // two-entry table out of reset: full range, extreme values
    send_item(CMD_WRITE, 8'd0, 16'h0000, 32'h8000_0000);
    send_item(CMD_WRITE, 8'd1, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(CMD_QUERY, 8'hFF, 16'h0000, $urandom);
    send_item(CMD_QUERY, 8'hFF, 16'hFFFF, $urandom);
    send_item(CMD_QUERY, 8'hFF, 16'h0001, $urandom);
    send_item(CMD_QUERY, 8'hFF, 16'h8000, $urandom);
    send_item(CMD_QUERY, 8'hFF, 16'hFFFE, $urandom);
    // minus one and zero at half weight: rounds down to minus one
    send_item(CMD_WRITE, 8'd0, 16'h0100, 32'hFFFF_FFFF);
    send_item(CMD_WRITE, 8'd1, 16'h0300, 32'h0000_0000);
    send_item(CMD_QUERY, 8'h00, 16'h0200, $urandom);
    send_item(CMD_QUERY, 8'h00, 16'h0101, $urandom);
    // equal breakpoints
    send_item(CMD_WRITE, 8'd1, 16'h0100, 32'h7FFF_FFFF);
    send_item(CMD_QUERY, 8'h00, 16'h00FF, $urandom);
    send_item(CMD_QUERY, 8'h00, 16'h0100, $urandom);
    send_item(CMD_QUERY, 8'h00, 16'h0101, $urandom);
    // decreasing breakpoints
    send_item(CMD_WRITE, 8'd1, 16'h0080, 32'h0000_0001);
    send_item(CMD_QUERY, 8'h00, 16'h00C0, $urandom);
    // adjacent breakpoints two apart
    send_item(CMD_WRITE, 8'd0, 16'h4000, 32'h0001_0000);
    send_item(CMD_WRITE, 8'd1, 16'h4002, 32'h0002_0000);
    send_item(CMD_QUERY, 8'h00, 16'h4001, $urandom);
    send_item(CMD_WRITE, 8'd255, 16'hABCD, 32'h5555_5555);
    send_item(CMD_QUERY, 8'h00, 16'h4000, $urandom);
    send_item(CMD_QUERY, 8'h00, 16'h4002, $urandom);

    run_phase(9'd511);
    run_phase(9'd0);
    run_phase(9'd5);
    no_idle = 1'b1;
    run_phase(9'd16);
    no_idle = 1'b0;
    run_phase(9'd257);
    run_phase(9'd1);
    run_phase(9'd3);
    run_phase(9'd256);
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) cnt = 9'($urandom_range(0, 511));
      else cnt = 9'($urandom_range(2, 24));
      run_phase(cnt);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
